// ===== rtl/core/gie_pkg.sv =====
// ----------------------------------------------------------------------------
// gie_pkg
// Shared widths, register indexes and pipeline types for the geohash
// interleave encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gie_pkg;

    // Number of bisection steps (one pipeline stage each) and coordinate width.
    localparam int MAX_STEPS  = 32;
    localparam int COORD_BITS = 31;

    // Extra fraction bits that keep every midpoint exact.
    localparam int FRAC_BITS  = 32;

    // Width of the step-count field.
    localparam int DEPTH_W    = 6;

    // Derived widths.
    localparam int POS_W      = COORD_BITS + FRAC_BITS;   // relative position
    localparam int SUM_W      = POS_W + 1;                // lo + hi before halving
    localparam int HASH_W     = 2 * MAX_STEPS;            // full interleaved hash
    localparam int SH_W       = (HASH_W > 2) ? $clog2(HASH_W) : 1;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LAT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LON_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LON_MAX = 2'd3;

    // Reset values of the range registers: the full signed span.
    localparam logic [COORD_BITS-1:0] COORD_LOW  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] COORD_HIGH = {1'b0, {(COORD_BITS-1){1'b1}}};

    // Payload carried from stage to stage. Ranges are held relative to the
    // range minimum, scaled by 2^FRAC_BITS.
    typedef struct packed {
        logic               err;
        logic [DEPTH_W-1:0] depth;
        logic [POS_W-1:0]   lat_pos;
        logic [POS_W-1:0]   lon_pos;
        logic [POS_W-1:0]   lat_lo;
        logic [POS_W-1:0]   lat_hi;
        logic [POS_W-1:0]   lon_lo;
        logic [POS_W-1:0]   lon_hi;
        logic [HASH_W-1:0]  hash;
    } t_bis;

endpackage

`default_nettype wire

// ===== rtl/core/gie_prep.sv =====
// ----------------------------------------------------------------------------
// gie_prep
// Entry stage: range and step-count checks, positions relative to the range
// minimum, initial bisection interval.
// ----------------------------------------------------------------------------
`default_nettype none

module gie_prep (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0] i_lat_coord,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0] i_lon_coord,
    input  wire logic        [gie_pkg::DEPTH_W-1:0]    i_depth,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0] i_lat_min,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0] i_lat_max,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0] i_lon_min,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0] i_lon_max,
    output logic                                      o_valid,
    output gie_pkg::t_bis                             o_data
);

    localparam int XW = gie_pkg::COORD_BITS + 1;

    logic signed [XW-1:0] lat_x, lon_x, lat_lo_x, lat_hi_x, lon_lo_x, lon_hi_x;
    logic signed [XW-1:0] lat_rel, lon_rel, lat_span, lon_span;
    logic                 depth_bad, out_of_range;

    logic          r_valid;
    gie_pkg::t_bis r_data;
    gie_pkg::t_bis n_data;

    always_comb begin
        lat_x    = XW'(i_lat_coord);
        lon_x    = XW'(i_lon_coord);
        lat_lo_x = XW'(i_lat_min);
        lat_hi_x = XW'(i_lat_max);
        lon_lo_x = XW'(i_lon_min);
        lon_hi_x = XW'(i_lon_max);

        lat_rel  = lat_x - lat_lo_x;
        lon_rel  = lon_x - lon_lo_x;
        lat_span = lat_hi_x - lat_lo_x;
        lon_span = lon_hi_x - lon_lo_x;

        depth_bad = (i_depth == '0) ||
                    (i_depth > gie_pkg::DEPTH_W'(gie_pkg::MAX_STEPS));
        out_of_range = (lat_x < lat_lo_x) || (lat_x > lat_hi_x) ||
                       (lon_x < lon_lo_x) || (lon_x > lon_hi_x);

        n_data.err     = depth_bad || out_of_range;
        n_data.depth   = i_depth;
        n_data.lat_pos = {lat_rel[gie_pkg::COORD_BITS-1:0], {gie_pkg::FRAC_BITS{1'b0}}};
        n_data.lon_pos = {lon_rel[gie_pkg::COORD_BITS-1:0], {gie_pkg::FRAC_BITS{1'b0}}};
        n_data.lat_lo  = '0;
        n_data.lat_hi  = {lat_span[gie_pkg::COORD_BITS-1:0], {gie_pkg::FRAC_BITS{1'b0}}};
        n_data.lon_lo  = '0;
        n_data.lon_hi  = {lon_span[gie_pkg::COORD_BITS-1:0], {gie_pkg::FRAC_BITS{1'b0}}};
        n_data.hash    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/gie_bisect_stage.sv =====
// ----------------------------------------------------------------------------
// gie_bisect_stage
// One bisection step for both axes; appends the longitude and latitude bit
// to the hash.
// ----------------------------------------------------------------------------
`default_nettype none

module gie_bisect_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire gie_pkg::t_bis i_data,
    output logic               o_valid,
    output gie_pkg::t_bis      o_data
);

    logic [gie_pkg::SUM_W-1:0] lat_sum, lon_sum;
    logic [gie_pkg::POS_W-1:0] lat_mid, lon_mid;
    logic                      lat_bit, lon_bit;

    logic          r_valid;
    gie_pkg::t_bis r_data;
    gie_pkg::t_bis n_data;

    always_comb begin
        lat_sum = {1'b0, i_data.lat_lo} + {1'b0, i_data.lat_hi};
        lon_sum = {1'b0, i_data.lon_lo} + {1'b0, i_data.lon_hi};
        lat_mid = lat_sum[gie_pkg::SUM_W-1:1];
        lon_mid = lon_sum[gie_pkg::SUM_W-1:1];

        // At or below the midpoint keeps the lower half.
        lat_bit = i_data.lat_pos > lat_mid;
        lon_bit = i_data.lon_pos > lon_mid;

        n_data        = i_data;
        n_data.lat_lo = lat_bit ? lat_mid : i_data.lat_lo;
        n_data.lat_hi = lat_bit ? i_data.lat_hi : lat_mid;
        n_data.lon_lo = lon_bit ? lon_mid : i_data.lon_lo;
        n_data.lon_hi = lon_bit ? i_data.lon_hi : lon_mid;
        n_data.hash   = (i_data.hash << 2) | gie_pkg::HASH_W'({lon_bit, lat_bit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/gie_align.sv =====
// ----------------------------------------------------------------------------
// gie_align
// Output stage: right-aligns the first depth bit pairs of the full hash and
// forces zero on error.
// ----------------------------------------------------------------------------
`default_nettype none

module gie_align (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire gie_pkg::t_bis               i_data,
    output logic                             o_done,
    output logic [gie_pkg::HASH_W-1:0]       o_hash_bits,
    output logic                             o_error
);

    logic [gie_pkg::DEPTH_W:0]   steps_left;
    logic [gie_pkg::SH_W-1:0]    shamt;

    logic                        r_done;
    logic [gie_pkg::HASH_W-1:0]  r_hash;
    logic                        r_error;
    logic [gie_pkg::HASH_W-1:0]  n_hash;

    always_comb begin
        // Drop the pairs produced past the requested step count.
        steps_left = (gie_pkg::DEPTH_W+1)'(gie_pkg::MAX_STEPS) - {1'b0, i_data.depth};
        shamt      = gie_pkg::SH_W'({steps_left, 1'b0});
        n_hash     = i_data.err ? '0 : (i_data.hash >> shamt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
        r_hash  <= n_hash;
        r_error <= i_data.err;
    end

    assign o_done      = r_done;
    assign o_hash_bits = r_hash;
    assign o_error     = r_error;

endmodule

`default_nettype wire

// ===== rtl/core/geohash_interleave_encoder.sv =====
// ----------------------------------------------------------------------------
// geohash_interleave_encoder
// Binary interleaved geohash encoder: bisects the configured latitude and
// longitude ranges once per pipeline stage, longitude bit above latitude bit.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  item in  | start, busy             | i_lat_coord, i_lon_coord, i_depth
//  item out | o_done (one-cycle pulse)| o_hash_bits, o_error
//  config   | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
//  Pipeline: a fully pipelined datapath of MAX_STEPS + 2 register stages (entry
//  check, one stage per bisection step, output alignment) accepts one item
//  every cycle, except while reset is asserted.
//  Each bisection stage holds one exact 64-bit add and 63-bit compare per axis.
//  Reset: synchronous, active low; clears the valid bits and sets the ranges
//  to the full signed span. busy is high only while reset is asserted.
//  Stalls: the receiver cannot stall, so the pipeline never holds; results
//  leave in the order items entered.
// ----------------------------------------------------------------------------
`default_nettype none

module geohash_interleave_encoder (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,

    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0]  i_lat_coord,
    input  wire logic signed [gie_pkg::COORD_BITS-1:0]  i_lon_coord,
    input  wire logic        [gie_pkg::DEPTH_W-1:0]     i_depth,

    output logic                                        o_done,
    output logic             [gie_pkg::HASH_W-1:0]      o_hash_bits,
    output logic                                        o_error,

    input  wire logic                                   i_cfg_we,
    input  wire logic        [gie_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic        [gie_pkg::COORD_BITS-1:0]  i_cfg_data
);

    // Range registers.
    logic signed [gie_pkg::COORD_BITS-1:0] r_lat_min, r_lat_max, r_lon_min, r_lon_max;
    logic signed [gie_pkg::COORD_BITS-1:0] n_lat_min, n_lat_max, n_lon_min, n_lon_max;

    // Pipeline links: entry stage feeds link 0, bisection stage k feeds k+1.
    logic          stg_valid [gie_pkg::MAX_STEPS+1];
    gie_pkg::t_bis stg_data  [gie_pkg::MAX_STEPS+1];

    logic accept;

    // The datapath takes an item every cycle; hold off only during reset.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Configuration write decode.
    always_comb begin
        n_lat_min = r_lat_min;
        n_lat_max = r_lat_max;
        n_lon_min = r_lon_min;
        n_lon_max = r_lon_max;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gie_pkg::REG_LAT_MIN: n_lat_min = i_cfg_data;
                gie_pkg::REG_LAT_MAX: n_lat_max = i_cfg_data;
                gie_pkg::REG_LON_MIN: n_lon_min = i_cfg_data;
                gie_pkg::REG_LON_MAX: n_lon_max = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_min <= gie_pkg::COORD_LOW;
            r_lat_max <= gie_pkg::COORD_HIGH;
            r_lon_min <= gie_pkg::COORD_LOW;
            r_lon_max <= gie_pkg::COORD_HIGH;
        end else begin
            r_lat_min <= n_lat_min;
            r_lat_max <= n_lat_max;
            r_lon_min <= n_lon_min;
            r_lon_max <= n_lon_max;
        end
    end

    // Entry: check the point and step count, move to range-relative positions.
    gie_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_lat_coord (i_lat_coord),
        .i_lon_coord (i_lon_coord),
        .i_depth     (i_depth),
        .i_lat_min   (r_lat_min),
        .i_lat_max   (r_lat_max),
        .i_lon_min   (r_lon_min),
        .i_lon_max   (r_lon_max),
        .o_valid     (stg_valid[0]),
        .o_data      (stg_data[0])
    );

    // One bisection stage per step; all MAX_STEPS steps always run and the
    // output stage keeps only the requested ones.
    for (genvar k = 0; k < gie_pkg::MAX_STEPS; k++) begin : g_step
        gie_bisect_stage u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .i_data  (stg_data[k]),
            .o_valid (stg_valid[k+1]),
            .o_data  (stg_data[k+1])
        );
    end

    // Output: right-align the hash, zero it on error, pulse o_done.
    gie_align u_align (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid[gie_pkg::MAX_STEPS]),
        .i_data      (stg_data[gie_pkg::MAX_STEPS]),
        .o_done      (o_done),
        .o_hash_bits (o_hash_bits),
        .o_error     (o_error)
    );

endmodule

`default_nettype wire

// ===== verif/tb_geohash_interleave_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_geohash_interleave_encoder
// Self-checking bench for the interleaved geohash encoder: a scoreboard class
// predicts hash and error flag for every accepted point, random points and
// range settings stress the bisection pipeline under changing input gaps.
// ----------------------------------------------------------------------------

module tb_geohash_interleave_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import gie_pkg::*;

    // Pipeline depth from the block header: entry check, one stage per step,
    // output alignment.
    localparam int PIPE_LATENCY = MAX_STEPS + 2;

    // Give up after this many cycles without any accepted item, result or
    // register write. The slowest correct gap is a pipeline drain plus a long
    // run of sender idles, far below this.
    localparam int STALL_LIMIT = 4000;

    localparam int SEGMENTS      = 9;
    localparam int ITEMS_PER_SEG = 150;

    // Signed span of a coordinate.
    localparam longint CRD_MIN = -(longint'(1) << (COORD_BITS - 1));
    localparam longint CRD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              err;
    } hash_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own copy of the four range registers and a queue
    // of predicted hashes, oldest first.
    // ------------------------------------------------------------------------
    class geohash_tracker;
        logic signed [COORD_BITS-1:0] lat_lo_reg, lat_hi_reg, lon_lo_reg, lon_hi_reg;
        hash_result_t queued_hashes[$];
        int unsigned  mismatches;
        int unsigned  points_seen;
        int unsigned  flagged_seen;
        int unsigned  reg_writes;

        function new();
            lat_lo_reg = COORD_LOW;
            lat_hi_reg = COORD_HIGH;
            lon_lo_reg = COORD_LOW;
            lon_hi_reg = COORD_HIGH;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] data);
            reg_writes++;
            case (idx)
                REG_LAT_MIN: lat_lo_reg = data;
                REG_LAT_MAX: lat_hi_reg = data;
                REG_LON_MIN: lon_lo_reg = data;
                REG_LON_MAX: lon_hi_reg = data;
                default: ;
            endcase
        endfunction

        // Bisect both ranges depth times, positions relative to each minimum
        // with FRAC_BITS of fraction so every midpoint stays exact.
        function void note_item(logic signed [COORD_BITS-1:0] lat,
                                logic signed [COORD_BITS-1:0] lon,
                                logic [DEPTH_W-1:0] depth);
            longint       la, lo, la_min, la_max, lo_min, lo_max;
            bit [63:0]    la_pos, lo_pos, la_a, la_b, lo_a, lo_b, mid;
            bit           lat_bit, lon_bit;
            hash_result_t r;
            la     = lat;
            lo     = lon;
            la_min = lat_lo_reg;
            la_max = lat_hi_reg;
            lo_min = lon_lo_reg;
            lo_max = lon_hi_reg;
            points_seen++;
            r.hash = '0;
            r.err  = 1'b0;
            if (depth == 0 || depth > MAX_STEPS || la < la_min || la > la_max ||
                lo < lo_min || lo > lo_max) begin
                r.err = 1'b1;
                flagged_seen++;
            end else begin
                la_pos = la - la_min;
                la_pos = la_pos << FRAC_BITS;
                lo_pos = lo - lo_min;
                lo_pos = lo_pos << FRAC_BITS;
                la_a   = '0;
                la_b   = la_max - la_min;
                la_b   = la_b << FRAC_BITS;
                lo_a   = '0;
                lo_b   = lo_max - lo_min;
                lo_b   = lo_b << FRAC_BITS;
                for (int i = 0; i < depth; i++) begin
                    mid = (la_a + la_b) >> 1;
                    lat_bit = (la_pos > mid);
                    if (lat_bit) la_a = mid; else la_b = mid;
                    mid = (lo_a + lo_b) >> 1;
                    lon_bit = (lo_pos > mid);
                    if (lon_bit) lo_a = mid; else lo_b = mid;
                    r.hash = {r.hash[HASH_W-3:0], lon_bit, lat_bit};
                end
            end
            queued_hashes.push_back(r);
        endfunction

        function void check_result(logic [HASH_W-1:0] hash, logic err);
            hash_result_t want;
            if (queued_hashes.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result: hash=%h error=%b", $time, hash, err);
                mismatches++;
            end else begin
                want = queued_hashes.pop_front();
                if (hash !== want.hash || err !== want.err) begin
                    if (mismatches < 10)
                        $display("[%0t] mismatch: expected hash=%h error=%b, got hash=%h error=%b",
                                 $time, want.hash, want.err, hash, err);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return queued_hashes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test. Every input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic signed [COORD_BITS-1:0] i_lat_coord = '0;
    logic signed [COORD_BITS-1:0] i_lon_coord = '0;
    logic [DEPTH_W-1:0]           i_depth     = '0;
    logic                         i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx   = '0;
    logic [COORD_BITS-1:0]        i_cfg_data  = '0;
    logic                         busy;
    logic                         o_done;
    logic [HASH_W-1:0]            o_hash_bits;
    logic                         o_error;

    geohash_interleave_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_lat_coord (i_lat_coord),
        .i_lon_coord (i_lon_coord),
        .i_depth     (i_depth),
        .o_done      (o_done),
        .o_hash_bits (o_hash_bits),
        .o_error     (o_error),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    geohash_tracker tracker = new();

    // Current range setting, mirrored here so random points can aim at it.
    longint lat_lo_cfg = CRD_MIN, lat_hi_cfg = CRD_MAX;
    longint lon_lo_cfg = CRD_MIN, lon_hi_cfg = CRD_MAX;
    int     idle_pct       = 0;
    int     range_settings = 1;
    int     quiet_cycles   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample everything at the rising edge, before the edge's own
    // updates land. Check the result first: it belongs to an older item.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                tracker.check_result(o_hash_bits, o_error);
            if (i_cfg_we)
                tracker.write_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                tracker.note_item(i_lat_coord, i_lon_coord, i_depth);
        end
    end

    // Watchdog: count cycles in which nothing moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. All are entered and left at a rising edge.
    // ------------------------------------------------------------------------

    // Present one item and hold it until an edge sees busy low.
    task automatic send_point(longint lat, longint lon, int depth);
        start       <= 1'b1;
        i_lat_coord <= lat[COORD_BITS-1:0];
        i_lon_coord <= lon[COORD_BITS-1:0];
        i_depth     <= depth[DEPTH_W-1:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Idle the sender for a random number of cycles at the current rate.
    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every predicted hash has come back.
    task automatic drain();
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Drain, then write all four range registers on consecutive edges.
    task automatic write_ranges(longint la_lo, longint la_hi, longint lo_lo, longint lo_hi);
        longint vals[4];
        logic [CFG_IDX_W-1:0] idxs[4];
        vals = '{la_lo, la_hi, lo_lo, lo_hi};
        idxs = '{REG_LAT_MIN, REG_LAT_MAX, REG_LON_MIN, REG_LON_MAX};
        drain();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k][COORD_BITS-1:0];
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        lat_lo_cfg = la_lo;
        lat_hi_cfg = la_hi;
        lon_lo_cfg = lo_lo;
        lon_hi_cfg = lo_hi;
        range_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------------

    function automatic longint any_coord();
        return CRD_MIN + longint'($urandom_range(32'h7FFF_FFFF));
    endfunction

    // Mostly inside [lo, hi], some on or just past a bound, some outside,
    // some anywhere in the signed span.
    function automatic longint pick_coord(longint lo, longint hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (lo > hi || roll < 10)
            return any_coord();
        if (roll < 16) begin
            case ($urandom_range(3))
                0: return lo;
                1: return hi;
                2: return (lo > CRD_MIN) ? lo - 1 : lo;
                default: return (hi < CRD_MAX) ? hi + 1 : hi;
            endcase
        end
        if (roll < 22) begin
            if (lo > CRD_MIN && (hi == CRD_MAX || $urandom_range(1) == 0))
                return CRD_MIN + longint'($urandom_range(int'(lo - 1 - CRD_MIN)));
            if (hi < CRD_MAX)
                return hi + 1 + longint'($urandom_range(int'(CRD_MAX - hi - 1)));
        end
        return lo + longint'($urandom_range(int'(hi - lo)));
    endfunction

    // Mostly a valid step count, now and then anything the field holds.
    function automatic int pick_depth();
        if ($urandom_range(99) < 12)
            return $urandom_range(63);
        return $urandom_range(MAX_STEPS, 1);
    endfunction

    // A range anywhere in the span, or a narrow one when asked.
    task automatic pick_range(bit narrow, output longint lo, output longint hi);
        longint a, b;
        a = any_coord();
        if (narrow) begin
            b = a + longint'($urandom_range(255));
            if (b > CRD_MAX) b = CRD_MAX;
        end else begin
            b = any_coord();
        end
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        longint la_lo, la_hi, lo_lo, lo_hi;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset ranges: invalid step counts, the corners of the span, then two points beside zero.
        send_point(0, 0, 0);
        send_point(0, 0, MAX_STEPS + 1);
        send_point(0, 0, 63);
        send_point(CRD_MIN, CRD_MIN, MAX_STEPS);
        send_point(CRD_MAX, CRD_MAX, MAX_STEPS);
        send_point(CRD_MIN, CRD_MAX, 1);
        send_point(CRD_MAX, CRD_MIN, MAX_STEPS);
        send_point(0, -1, MAX_STEPS);
        send_point(-1, 0, 17);

        // Narrow ranges: one step past each bound, then on the bounds and
        // the exact latitude midpoint.
        write_ranges(-1000, 1000, -5000, 20);
        send_point(-1001, 0, 8);
        send_point(1001, 0, 8);
        send_point(0, -5001, 8);
        send_point(0, 21, 8);
        send_point(-1000, 20, MAX_STEPS);
        send_point(1000, -5000, MAX_STEPS);
        send_point(0, 0, MAX_STEPS);

        // Degenerate ranges: the one point inside hashes to all zeros.
        write_ranges(7, 7, -3, -3);
        send_point(7, -3, MAX_STEPS);
        send_point(8, -3, 5);

        // Inverted latitude range: nothing lies inside.
        write_ranges(100, -100, CRD_MIN, CRD_MAX);
        send_point(0, 0, 4);
        send_point(100, 0, 4);

        // Random segments: sender idles 22 percent, then 77, then never.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct = (seg < 3) ? 22 : (seg < 6) ? 77 : 0;
            case (seg)
                0: begin
                    la_lo = CRD_MIN; la_hi = CRD_MAX;
                    lo_lo = CRD_MIN; lo_hi = CRD_MAX;
                end
                2: begin
                    pick_range(1'b1, la_lo, la_hi);
                    pick_range(1'b1, lo_lo, lo_hi);
                end
                3: begin
                    pick_range(1'b0, la_lo, la_hi);
                    pick_range(1'b1, lo_lo, lo_hi);
                end
                4: begin
                    la_lo = CRD_MIN; la_hi = CRD_MAX;
                    lo_lo = any_coord(); lo_hi = lo_lo;
                end
                6: begin
                    pick_range(1'b1, la_lo, la_hi);
                    lo_lo = CRD_MIN; lo_hi = CRD_MAX;
                end
                8: begin
                    la_lo = CRD_MAX; la_hi = CRD_MAX;
                    lo_lo = CRD_MIN; lo_hi = CRD_MIN + 1;
                end
                default: begin
                    pick_range(1'b0, la_lo, la_hi);
                    pick_range(1'b0, lo_lo, lo_hi);
                end
            endcase
            write_ranges(la_lo, la_hi, lo_lo, lo_hi);
            repeat (ITEMS_PER_SEG) begin
                idle_gap();
                send_point(pick_coord(lat_lo_cfg, lat_hi_cfg),
                           pick_coord(lon_lo_cfg, lon_hi_cfg), pick_depth());
            end
        end

        // Drain, then wait on past the pipeline depth for stray results.
        drain();
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);

        $display("Encoded %0d points (%0d flagged as errors) over %0d range settings,",
                 tracker.points_seen, tracker.flagged_seen, range_settings);
        $display("with %0d register writes and sender idle rates of 22, 77 and 0 percent.",
                 tracker.reg_writes);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     tracker.mismatches, tracker.pending());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gie_pkg.sv
rtl/core/gie_prep.sv
rtl/core/gie_bisect_stage.sv
rtl/core/gie_align.sv
rtl/core/geohash_interleave_encoder.sv
verif/tb_geohash_interleave_encoder.sv
